// ===== hw/rtl/axrot_pkg.sv =====
// shared constants, types and tables of the axis rotation matrix block
`default_nettype none

package axrot_pkg;

	// default parameter values
	localparam int ANGLE_FRAC_DEF    = 6;
	localparam int COEF_FRAC_DEF     = 14;
	localparam int CORDIC_STAGES_DEF = 16;

	// datapath widths
	localparam int XY_W   = 32;   // cordic x and y, signed Q2.30
	localparam int Z_W    = 33;   // cordic residual angle, signed turns
	localparam int U_W    = 21;   // offset angle, always positive
	localparam int X_W    = 38;   // phase dividend
	localparam int XL_W   = 19;   // split point of the dividend
	localparam int RCP_W  = 33;
	localparam int PP_W   = XL_W + RCP_W;
	localparam int SUM_W  = PP_W + XL_W;
	localparam int Q_LSB  = 38;
	localparam int REM_W  = 7;
	localparam int P_W    = 32;
	localparam int ELEM_W = 16;

	// phase is (angle * 2^32 + 360/2) / 360, reduced to a divide by 45
	localparam int                 MOD_DIV   = 45;
	localparam logic [REM_W-1:0]   MOD_BASE  = 7'd45;
	localparam int                 HALF_BASE = 22;
	localparam logic [U_W-1:0]     TURN_OFFS = 21'd1474560;        // 45 * 2^15
	localparam logic [RCP_W-1:0]   RECIP45   = 33'd6108397932;     // floor(2^38 / 45)
	localparam logic [XY_W-1:0]    CORDIC_GAIN = 32'd652032874;

	// axis characters and internal axis codes
	localparam logic [7:0] CHAR_X = 8'd120;
	localparam logic [7:0] CHAR_Y = 8'd121;
	localparam logic [7:0] CHAR_Z = 8'd122;

	localparam logic [1:0] AX_X   = 2'd0;
	localparam logic [1:0] AX_Y   = 2'd1;
	localparam logic [1:0] AX_Z   = 2'd2;
	localparam logic [1:0] AX_BAD = 2'd3;

	// matrix vector numbers
	localparam logic [1:0] ROW_X = 2'd0;
	localparam logic [1:0] ROW_Y = 2'd1;
	localparam logic [1:0] ROW_Z = 2'd2;
	localparam logic [1:0] ROW_W = 2'd3;

	typedef struct packed {
		logic [ELEM_W-1:0] e0;
		logic [ELEM_W-1:0] e1;
		logic [ELEM_W-1:0] e2;
		logic [ELEM_W-1:0] e3;
	} row_t;

	function automatic logic [1:0] axis_code(input logic [7:0] ch);
		logic [1:0] code;
		case (ch)
			CHAR_X:  code = AX_X;
			CHAR_Y:  code = AX_Y;
			CHAR_Z:  code = AX_Z;
			default: code = AX_BAD;
		endcase
		return code;
	endfunction

	// arctangent of 2^-idx in turns, Q0.32, truncated
	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] a;
		case (idx)
			0:       a = 32'h20000000;
			1:       a = 32'h12E4051E;
			2:       a = 32'h09FB385B;
			3:       a = 32'h051111D4;
			4:       a = 32'h028B0D43;
			5:       a = 32'h0145D7E1;
			6:       a = 32'h00A2F61E;
			7:       a = 32'h00517C55;
			8:       a = 32'h0028BE53;
			9:       a = 32'h00145F2F;
			10:      a = 32'h000A2F98;
			11:      a = 32'h000517CC;
			12:      a = 32'h00028BE6;
			13:      a = 32'h000145F3;
			14:      a = 32'h0000A2F9;
			15:      a = 32'h0000517C;
			16:      a = 32'h000028BE;
			17:      a = 32'h0000145F;
			18:      a = 32'h00000A2F;
			19:      a = 32'h00000517;
			20:      a = 32'h0000028B;
			21:      a = 32'h00000145;
			22:      a = 32'h000000A2;
			23:      a = 32'h00000051;
			24:      a = 32'h00000028;
			25:      a = 32'h00000014;
			26:      a = 32'h0000000A;
			27:      a = 32'h00000005;
			28:      a = 32'h00000002;
			29:      a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// one vector of the rotation matrix, entries already cut to 16 bits
	function automatic row_t matrix_row(input logic [1:0] ax, input logic [1:0] row,
			input logic [ELEM_W-1:0] c, input logic [ELEM_W-1:0] s,
			input logic [ELEM_W-1:0] one);
		row_t r;
		logic [ELEM_W-1:0] ns;
		ns = ~s + 16'd1;
		r  = '0;
		if (row == ROW_W) begin
			r.e3 = one;
		end else begin
			case (ax)
				AX_Z: begin
					case (row)
						ROW_X:   begin r.e0 = c;  r.e1 = s; end
						ROW_Y:   begin r.e0 = ns; r.e1 = c; end
						ROW_Z:   r.e2 = one;
						default: r = '0;
					endcase
				end
				AX_X: begin
					case (row)
						ROW_X:   r.e0 = one;
						ROW_Y:   begin r.e1 = c;  r.e2 = s; end
						ROW_Z:   begin r.e1 = ns; r.e2 = c; end
						default: r = '0;
					endcase
				end
				AX_Y: begin
					case (row)
						ROW_X:   begin r.e0 = c; r.e2 = ns; end
						ROW_Y:   r.e1 = one;
						ROW_Z:   begin r.e0 = s; r.e2 = c; end
						default: r = '0;
					endcase
				end
				default: r = '0;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/axis_rotation_matrix_top.sv =====
// axis rotation matrix: angle to cos/sin by pipelined cordic, then four matrix vectors
`default_nettype none

// Takes an angle in degrees (signed, ANGLE_FRAC_BITS fraction bits) and an axis letter
// 'x', 'y' or 'z' when start is high and busy is low, and returns the four vectors x, y,
// z, w of the homogeneous rotation matrix, one word per cycle marked by done, row_index
// 0 to 3, last on the fourth. Any other axis letter gives one word with status set, all
// entries zero and last set. The angle is reduced to a phase in turns through a divide
// by 45 done with a split reciprocal multiply, then runs through CORDIC_STAGES cordic
// stages, one per register stage; the pipeline itself could take a new angle every
// cycle. The single result port sets the rate: after a valid axis busy stays high
// until the port has had room for its four vectors, so the next such item waits;
// an invalid axis item can be followed in the next cycle. The receiver cannot stall,
// and done holds for exactly one cycle per word.
module axis_rotation_matrix_top #(
	parameter int ANGLE_FRAC_BITS = axrot_pkg::ANGLE_FRAC_DEF,
	parameter int COEF_FRAC_BITS  = axrot_pkg::COEF_FRAC_DEF,
	parameter int CORDIC_STAGES   = axrot_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] angle_deg,
	input  logic        [7:0]  axis_char,
	output logic               busy,
	output logic               done,
	output logic        [1:0]  row_index,
	output logic signed [15:0] elem0,
	output logic signed [15:0] elem1,
	output logic signed [15:0] elem2,
	output logic signed [15:0] elem3,
	output logic               status,
	output logic               last
);
	import axrot_pkg::*;

	localparam int LO_W  = ANGLE_FRAC_BITS + 3;
	localparam int V_W   = U_W - LO_W;
	localparam int S_W   = P_W - LO_W;
	localparam int KV    = V_W + 6;
	localparam int VP_W  = V_W + KV;
	localparam logic [KV-1:0] RV = KV'((64'd1 << KV) / MOD_DIV);
	localparam int SH    = 30 - COEF_FRAC_BITS;
	localparam int XR_W  = XY_W + 1;
	localparam logic signed [XR_W-1:0] RND  = XR_W'((64'd1 << SH) >> 1);
	localparam logic signed [XR_W-1:0] ONE  = XR_W'(64'd1 << COEF_FRAC_BITS);
	localparam logic signed [XR_W-1:0] MONE = -ONE;
	localparam logic [ELEM_W-1:0] ONE16 = ONE[ELEM_W-1:0];
	localparam logic [1:0] GAP_CYC = 2'd3;

	// input throttle
	logic [1:0] gap_q;
	logic       acc;

	assign busy = (gap_q != 2'd0);
	assign acc  = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (acc && axis_code(axis_char) != AX_BAD) begin
			gap_q <= GAP_CYC;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// pipeline registers
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic                     vld_s9, vld_s10;
	logic signed [15:0]       ang_s1;
	logic [1:0]               ax_s1, ax_s2, ax_s3, ax_s4, ax_s5, ax_s6, ax_s7, ax_s9, ax_s10;
	logic [REM_W-1:0]         v_s2, vq_s2, rem_s3, x_s5, x_s6, rem_s7;
	logic [LO_W-1:0]          lo_s2, lo_s3;
	logic [X_W-1:0]           x_s4;
	logic [PP_W-1:0]          pph_s5, ppl_s5;
	logic [P_W-1:0]           q_s6, q_s7;
	logic                     flp_s9;
	logic signed [XR_W-1:0]   cos_s9, sin_s9;
	logic [ELEM_W-1:0]        cos_s10, sin_s10;

	// cordic stages, index 0 is loaded from the phase fold
	logic                     vld_cs [CORDIC_STAGES+1];
	logic                     flp_cs [CORDIC_STAGES+1];
	logic [1:0]               ax_cs  [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]   cx_cs  [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]   cy_cs  [CORDIC_STAGES+1];
	logic signed [Z_W-1:0]    cz_cs  [CORDIC_STAGES+1];

	// combinational stage logic
	logic [U_W-1:0]           u_w;
	logic [VP_W-1:0]          vprod_w;
	logic [REM_W-1:0]         rem_w, rh_w, rem2_w;
	logic [SUM_W-1:0]         sum_w;
	logic [P_W-1:0]           p_w;
	logic                     flp_w;
	logic signed [XR_W-1:0]   xr_w, yr_w, cl_w, sl_w, cn_w, sn_w;

	always_comb begin
		// offset keeps the angle positive without moving its phase
		u_w     = U_W'(ang_s1) + TURN_OFFS;
		vprod_w = VP_W'(u_w[U_W-1:LO_W]) * VP_W'(RV);
		rem_w   = v_s2 - REM_W'(vq_s2 * MOD_BASE);
		rh_w    = (rem_s3 >= MOD_BASE) ? rem_s3 - MOD_BASE : rem_s3;
		sum_w   = (SUM_W'(pph_s5) << XL_W) + SUM_W'(ppl_s5);
		rem2_w  = x_s6 - REM_W'(q_s6[REM_W-1:0] * MOD_BASE);
		p_w     = q_s7 + P_W'(rem_s7 >= MOD_BASE);
		// fold the middle half turn onto the right half plane
		flp_w   = p_w[P_W-1] ^ p_w[P_W-2];
		xr_w    = (XR_W'(cx_cs[CORDIC_STAGES]) + RND) >>> SH;
		yr_w    = (XR_W'(cy_cs[CORDIC_STAGES]) + RND) >>> SH;
		cl_w    = (cos_s9 > ONE) ? ONE : ((cos_s9 < MONE) ? MONE : cos_s9);
		sl_w    = (sin_s9 > ONE) ? ONE : ((sin_s9 < MONE) ? MONE : sin_s9);
		cn_w    = flp_s9 ? -cl_w : cl_w;
		sn_w    = flp_s9 ? -sl_w : sl_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_cs[0] <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
		end else begin
			vld_s1    <= acc;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_cs[0] <= vld_s7;
			vld_s9    <= vld_cs[CORDIC_STAGES];
			vld_s10   <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1    <= angle_deg;
		ax_s1     <= axis_code(axis_char);

		v_s2      <= u_w[LO_W+REM_W-1:LO_W];
		vq_s2     <= vprod_w[KV+REM_W-1:KV];
		lo_s2     <= u_w[LO_W-1:0];
		ax_s2     <= ax_s1;

		rem_s3    <= rem_w;
		lo_s3     <= lo_s2;
		ax_s3     <= ax_s2;

		x_s4      <= {rh_w[5:0], lo_s3, S_W'(HALF_BASE)};
		ax_s4     <= ax_s3;

		pph_s5    <= PP_W'(x_s4[X_W-1:XL_W]) * PP_W'(RECIP45);
		ppl_s5    <= PP_W'(x_s4[XL_W-1:0]) * PP_W'(RECIP45);
		x_s5      <= x_s4[REM_W-1:0];
		ax_s5     <= ax_s4;

		q_s6      <= sum_w[Q_LSB+P_W-1:Q_LSB];
		x_s6      <= x_s5;
		ax_s6     <= ax_s5;

		rem_s7    <= rem2_w;
		q_s7      <= q_s6;
		ax_s7     <= ax_s6;

		cx_cs[0]  <= CORDIC_GAIN;
		cy_cs[0]  <= '0;
		cz_cs[0]  <= Z_W'($signed({p_w[P_W-1] ^ flp_w, p_w[P_W-2:0]}));
		flp_cs[0] <= flp_w;
		ax_cs[0]  <= ax_s7;

		cos_s9    <= xr_w;
		sin_s9    <= yr_w;
		flp_s9    <= flp_cs[CORDIC_STAGES];
		ax_s9     <= ax_cs[CORDIC_STAGES];

		cos_s10   <= cn_w[ELEM_W-1:0];
		sin_s10   <= sn_w[ELEM_W-1:0];
		ax_s10    <= ax_s9;
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		logic signed [XY_W-1:0] xs, ys;
		logic signed [Z_W-1:0]  at;
		logic                   pos;

		assign xs  = cx_cs[i] >>> i;
		assign ys  = cy_cs[i] >>> i;
		assign at  = $signed({1'b0, atan_turn(i)});
		assign pos = ~cz_cs[i][Z_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_cs[i+1] <= 1'b0;
			end else begin
				vld_cs[i+1] <= vld_cs[i];
			end
		end

		always_ff @(posedge clk) begin
			cx_cs[i+1]  <= pos ? cx_cs[i] - ys : cx_cs[i] + ys;
			cy_cs[i+1]  <= pos ? cy_cs[i] + xs : cy_cs[i] - xs;
			cz_cs[i+1]  <= pos ? cz_cs[i] - at : cz_cs[i] + at;
			flp_cs[i+1] <= flp_cs[i];
			ax_cs[i+1]  <= ax_cs[i];
		end
	end

	// output serializer: row 0 straight from the pipe, rows 1 to 3 from the hold registers
	logic              done_q, act_q;
	logic [1:0]        cnt_q, row_q, hax_q;
	logic [ELEM_W-1:0] hc_q, hs_q;
	logic              status_q, last_q;
	row_t              e_q, row_w;
	logic              bad_w;

	assign bad_w = (ax_s10 == AX_BAD);

	always_comb begin
		if (vld_s10) begin
			row_w = matrix_row(ax_s10, ROW_X, cos_s10, sin_s10, ONE16);
		end else begin
			row_w = matrix_row(hax_q, cnt_q, hc_q, hs_q, ONE16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			act_q  <= 1'b0;
			cnt_q  <= ROW_X;
		end else begin
			done_q <= vld_s10 | act_q;
			if (vld_s10) begin
				act_q <= ~bad_w;
				cnt_q <= ROW_Y;
			end else if (act_q) begin
				act_q <= (cnt_q != ROW_W);
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s10) begin
			hc_q  <= cos_s10;
			hs_q  <= sin_s10;
			hax_q <= ax_s10;
		end
		row_q    <= vld_s10 ? ROW_X : cnt_q;
		e_q      <= (vld_s10 && bad_w) ? '0 : row_w;
		status_q <= vld_s10 && bad_w;
		last_q   <= vld_s10 ? bad_w : (cnt_q == ROW_W);
	end

	assign done      = done_q;
	assign row_index = row_q;
	assign elem0     = e_q.e0;
	assign elem1     = e_q.e1;
	assign elem2     = e_q.e2;
	assign elem3     = e_q.e3;
	assign status    = status_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/axrot_check.sv =====
// port-level checker for the axis rotation matrix block, bound to the top level
`default_nettype none

module axrot_check (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic signed [15:0] angle_deg,
	input logic        [7:0]  axis_char,
	input logic               busy,
	input logic               done,
	input logic        [1:0]  row_index,
	input logic signed [15:0] elem0,
	input logic signed [15:0] elem1,
	input logic signed [15:0] elem2,
	input logic signed [15:0] elem3,
	input logic               status,
	input logic               last
);
	import axrot_pkg::*;

	// a valid axis holds off the next word so four vectors fit on the port
	a_busy_after_axis: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (axis_char == CHAR_X || axis_char == CHAR_Y || axis_char == CHAR_Z)
		|=> busy)
		else $error("busy not raised after a valid axis word");

	a_busy_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy) && $past(busy, 2) |=> !busy)
		else $error("busy held longer than three cycles");

	a_rows_follow: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done && row_index == $past(row_index) + 2'd1)
		else $error("matrix vectors not back to back");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> last && row_index == ROW_X && elem0 == 16'sd0 && elem1 == 16'sd0
			&& elem2 == 16'sd0 && elem3 == 16'sd0)
		else $error("bad axis word malformed");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		done && last && !status |-> row_index == ROW_W)
		else $error("last flag on wrong vector");

	// angle is only carried for the binding
	logic unused_ang;
	assign unused_ang = ^angle_deg;

endmodule

bind axis_rotation_matrix_top axrot_check u_axrot_check (.*);

`default_nettype wire

// ===== dv/axis_rotation_matrix_top_tb.sv =====
// testbench for the axis rotation matrix block: directed table, then random angles and axes
`timescale 1ns / 100ps

module axis_rotation_matrix_top_tb;
	import axrot_pkg::*;

	localparam int ANGLE_FRAC = 6;
	localparam int COEF_FRAC  = 14;
	localparam int STAGES     = 16;
	localparam int RAND_ITEMS = 500;
	localparam int CALM_AFTER = 400;   // no idling from this random word on
	localparam int MAX_SHOWN  = 10;

	localparam logic ST_OK       = 1'b0;
	localparam logic ST_BAD_AXIS = 1'b1;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint DEG_TURN = 64'sd360 <<< ANGLE_FRAC;
	localparam longint COEF_ONE = 64'sd1 <<< COEF_FRAC;

	// arctangent of 2^-i in Q0.32 turns
	localparam logic [31:0] ATAN_Q32 [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
	};

	typedef struct packed {
		logic [1:0]  row;
		logic [15:0] e0;
		logic [15:0] e1;
		logic [15:0] e2;
		logic [15:0] e3;
		logic        st;
		logic        lst;
	} mat_word_t;

	typedef struct packed {
		logic signed [15:0] ang;
		logic [7:0]         ax;
		bit                 bad_typed;   // expected error word typed in below
	} dir_item_t;

	localparam int DIR_N = 20;
	dir_item_t dir_tbl [DIR_N] = '{
		'{16'sd0, CHAR_X, 1'b0},
		'{16'sd0, CHAR_Y, 1'b0},
		'{16'sd0, CHAR_Z, 1'b0},
		'{16'sd5760, CHAR_Z, 1'b0},
		'{16'sd11520, CHAR_Z, 1'b0},
		'{16'sd17280, CHAR_Z, 1'b0},
		'{16'sd23040, CHAR_X, 1'b0},
		'{-16'sd5760, CHAR_Y, 1'b0},
		'{16'sd2880, CHAR_X, 1'b0},
		'{16'sd32767, CHAR_X, 1'b0},
		'{-16'sd32768, CHAR_Y, 1'b0},
		'{-16'sd1, CHAR_Z, 1'b0},
		'{16'sd1, CHAR_Y, 1'b0},
		'{16'sd8640, CHAR_Y, 1'b0},
		'{16'sd0, 8'd0, 1'b1},
		'{16'sd32767, 8'd255, 1'b1},
		'{-16'sd32768, 8'd119, 1'b1},
		'{16'sd5760, 8'd123, 1'b1},
		'{16'sd100, 8'd88, 1'b1},
		'{-16'sd1, 8'hAA, 1'b1}
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic signed [15:0] angle_deg;
	logic        [7:0]  axis_char;
	logic               busy;
	logic               done;
	logic        [1:0]  row_index;
	logic signed [15:0] elem0;
	logic signed [15:0] elem1;
	logic signed [15:0] elem2;
	logic signed [15:0] elem3;
	logic               status;
	logic               last;

	mat_word_t matrix_words_q [$];
	int        mismatch_cnt;

	axis_rotation_matrix_top #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC),
		.COEF_FRAC_BITS (COEF_FRAC),
		.CORDIC_STAGES  (STAGES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.angle_deg(angle_deg),
		.axis_char(axis_char),
		.busy     (busy),
		.done     (done),
		.row_index(row_index),
		.elem0    (elem0),
		.elem1    (elem1),
		.elem2    (elem2),
		.elem3    (elem3),
		.status   (status),
		.last     (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// round Q2.30 to the coefficient format and clamp to +-1
	function automatic longint q30_to_coef(input longint v);
		longint r;
		r = (v + (64'sd1 <<< (29 - COEF_FRAC))) >>> (30 - COEF_FRAC);
		if (r > COEF_ONE)
			r = COEF_ONE;
		if (r < -COEF_ONE)
			r = -COEF_ONE;
		return r;
	endfunction

	task automatic cordic_cos_sin(input logic signed [15:0] ang, output longint c,
			output longint s);
		longint          r;
		longint          z;
		longint          x;
		longint          y;
		longint          nx;
		longint          ny;
		longint unsigned num;
		logic [31:0]     p;
		bit              flip;
		r = longint'(ang) % DEG_TURN;
		if (r < 0)
			r += DEG_TURN;
		num = (longint'(r) << 32) + DEG_TURN / 2;
		p = 32'(num / DEG_TURN);
		flip = 1'b0;
		// fold the middle half turn onto the right half plane
		if (p >= 32'h4000_0000 && p < 32'hC000_0000) begin
			p = p - 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'($signed(p));
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= longint'(ATAN_Q32[i]);
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += longint'(ATAN_Q32[i]);
			end
			x = nx;
			y = ny;
		end
		c = q30_to_coef(x);
		s = q30_to_coef(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endtask

	task automatic predict_matrix(input logic signed [15:0] ang, input logic [7:0] ax);
		longint    c;
		longint    s;
		longint    m [4][4];
		mat_word_t w;
		if (ax != CHAR_X && ax != CHAR_Y && ax != CHAR_Z) begin
			matrix_words_q.push_back('{ROW_X, 16'd0, 16'd0, 16'd0, 16'd0, ST_BAD_AXIS, 1'b1});
			return;
		end
		cordic_cos_sin(ang, c, s);
		foreach (m[i, j])
			m[i][j] = 0;
		m[3][3] = COEF_ONE;
		case (ax)
			CHAR_Z: begin
				m[0][0] = c;  m[0][1] = s;
				m[1][0] = -s; m[1][1] = c;
				m[2][2] = COEF_ONE;
			end
			CHAR_X: begin
				m[0][0] = COEF_ONE;
				m[1][1] = c;  m[1][2] = s;
				m[2][1] = -s; m[2][2] = c;
			end
			default: begin
				m[0][0] = c;  m[0][2] = -s;
				m[1][1] = COEF_ONE;
				m[2][0] = s;  m[2][2] = c;
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			w.row = 2'(i);
			w.e0  = m[i][0][15:0];
			w.e1  = m[i][1][15:0];
			w.e2  = m[i][2][15:0];
			w.e3  = m[i][3][15:0];
			w.st  = ST_OK;
			w.lst = (i == 3);
			matrix_words_q.push_back(w);
		end
	endtask

	task automatic idle_burst();
		int n;
		n = $urandom_range(1, 16);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// present one word and hold it until the block takes it
	task automatic send_word(input logic signed [15:0] ang, input logic [7:0] ax);
		@(negedge clk);
		start     <= 1'b1;
		angle_deg <= ang;
		axis_char <= ax;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic logic signed [15:0] pick_angle();
		int k;
		int off;
		case ($urandom_range(0, 3))
			0, 1: return 16'($urandom);
			2: begin
				// near quadrant edges
				k = $urandom_range(0, 10) - 5;
				off = $urandom_range(0, 6) - 3;
				return 16'(k * 5760 + off);
			end
			default: begin
				k = $urandom_range(0, 22) - 11;
				off = $urandom_range(0, 40) - 20;
				return 16'(k * 2880 + off);
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_axis();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom);
		case ($urandom_range(0, 2))
			0:       return CHAR_X;
			1:       return CHAR_Y;
			default: return CHAR_Z;
		endcase
	endfunction

	always @(posedge clk) begin
		mat_word_t got;
		mat_word_t exp_w;
		if (arst_n && done) begin
			got = '{row_index, elem0, elem1, elem2, elem3, status, last};
			if (matrix_words_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_SHOWN)
					$display("unexpected word: row %0d elems %0d %0d %0d %0d",
						row_index, elem0, elem1, elem2, elem3,
						" status %0d last %0d", status, last);
			end else begin
				exp_w = matrix_words_q.pop_front();
				if (got.row !== exp_w.row || got.e0 !== exp_w.e0 || got.e1 !== exp_w.e1 ||
						got.e2 !== exp_w.e2 || got.e3 !== exp_w.e3 ||
						got.st !== exp_w.st || got.lst !== exp_w.lst) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_SHOWN)
						$display("mismatch: exp row %0d elems %0d %0d %0d %0d st %0d last %0d",
							exp_w.row, $signed(exp_w.e0), $signed(exp_w.e1),
							$signed(exp_w.e2), $signed(exp_w.e3), exp_w.st, exp_w.lst,
							", got row %0d elems %0d %0d %0d %0d st %0d last %0d",
							got.row, $signed(got.e0), $signed(got.e1),
							$signed(got.e2), $signed(got.e3), got.st, got.lst);
				end
			end
		end
	end

	initial begin
		logic signed [15:0] ang;
		logic [7:0]         ax;
		mismatch_cnt = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		angle_deg = '0;
		axis_char = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			if ($urandom_range(0, 3) == 0)
				idle_burst();
			send_word(dir_tbl[i].ang, dir_tbl[i].ax);
			if (dir_tbl[i].bad_typed)
				matrix_words_q.push_back('{ROW_X, 16'd0, 16'd0, 16'd0, 16'd0,
					ST_BAD_AXIS, 1'b1});
			else
				predict_matrix(dir_tbl[i].ang, dir_tbl[i].ax);
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i < CALM_AFTER && $urandom_range(0, 3) == 0)
				idle_burst();
			ang = pick_angle();
			ax  = pick_axis();
			send_word(ang, ax);
			predict_matrix(ang, ax);
		end
		@(negedge clk);
		start <= 1'b0;

		while (matrix_words_q.size() != 0)
			@(posedge clk);
		repeat (STAGES + 20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/axrot_pkg.sv
hw/rtl/axis_rotation_matrix_top.sv
hw/rtl/axrot_check.sv
dv/axis_rotation_matrix_top_tb.sv
